// ===== hw/rtl/line_sensor_calibrate_classify_core_assert.svh =====
// Assertion macros used by the top RTL file of the line sensor core.
`ifndef LINE_SENSOR_CALIBRATE_CLASSIFY_CORE_ASSERT_SVH
`define LINE_SENSOR_CALIBRATE_CLASSIFY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSCC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lscc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LSCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lscc assertion failed");

`endif

// ===== hw/rtl/lscc_pkg.sv =====
package lscc_pkg;

  localparam int MODE_W   = 2;
  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 10;
  localparam int MARGIN_W = 10;

  localparam logic [SAMPLE_W-1:0] MARK_TOP    = 10'd1023;
  localparam logic [SAMPLE_W-1:0] MARK_BOTTOM = 10'd0;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd50;

  localparam logic [MODE_W-1:0] MODE_START    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CAL      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

  localparam logic REG_MARGIN   = 1'b0;
  localparam logic REG_POLARITY = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [1:0] {
    OP_START,
    OP_CAL,
    OP_CLASSIFY,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                chan_ok;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [MARGIN_W-1:0] margin;
    logic                polarity;
  } cfg_t;

  typedef struct packed {
    logic                held;
    logic [SAMPLE_W-1:0] high;
    logic [SAMPLE_W-1:0] low;
  } entry_t;

endpackage

// ===== hw/rtl/line_sensor_calibrate_classify_core.sv =====
// Line sensor calibrate and classify core.
// Input channel: in_valid / in_stall carry one beat of mode, channel and
// sample. Mode start resets every channel's marks, calibration tracks the
// channel's minimum and maximum, classify after a start updates its held dark bit.
// Output channel: out_valid / out_stall carry one result beat per input
// beat, in order: classified, dark, all_separated, calibrated and the
// channel's low and high marks after that beat.
// Configuration: cfg_write with cfg_index selects margin (index 0) or
// polarity (index 1); write only while no beat is in flight.
// One beat is taken per cycle while out_stall stays low: the per-channel
// store is read in the cycle a beat leaves the queue and written back as
// that beat leaves the execute stage, with forwarding.
// When out_stall holds, the execute stage waits and the four-entry queue
// and front register fill; in_stall rises once both are occupied.
// A synchronous rst empties the pipeline and returns every channel to its
// reset marks through per-channel valid bits, with no clearing pass.
module line_sensor_calibrate_classify_core import lscc_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                classified,
  output logic                dark,
  output logic                all_separated,
  output logic                calibrated,
  output logic [SAMPLE_W-1:0] low_mark,
  output logic [SAMPLE_W-1:0] high_mark,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [MARGIN_W-1:0] cfg_data
);

  cfg_t          cfg;
  queue_status_t q_status;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.margin   <= MARGIN_RESET;
      cfg.polarity <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MARGIN:   cfg.margin   <= cfg_data;
        REG_POLARITY: cfg.polarity <= cfg_data[0];
      endcase
    end
  end

  lscc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .channel  (channel),
    .sample   (sample),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lscc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  lscc_back #(.CHANNELS(CHANNELS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .classified    (classified),
    .dark          (dark),
    .all_separated (all_separated),
    .calibrated    (calibrated),
    .low_mark      (low_mark),
    .high_mark     (high_mark)
  );

`include "line_sensor_calibrate_classify_core_assert.svh"

  // A classify result is only ever produced after a start.
  `LSCC_ASSERT_SAME(a_classified_needs_cal, clk, rst, out_valid && classified, calibrated)
  // The input side only stalls while the queue has no room.
  `LSCC_ASSERT_SAME(a_stall_when_full, clk, rst, in_stall, q_status.full)
  // Nothing leaves an empty queue.
  `LSCC_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, !q_status.empty)
  // Once a started result is delivered, later results stay calibrated.
  `LSCC_ASSERT_NEXT(a_cal_sticky, clk, rst, out_valid && !out_stall && calibrated,
                    !out_valid || calibrated)

endmodule

// ===== hw/rtl/lscc_front.sv =====
module lscc_front import lscc_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [SAMPLE_W-1:0] sample,
  input  queue_status_t       q_status,
  output logic                push,
  output cmd_t                push_cmd
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW    = (IDX_W > CHAN_W) ? IDX_W : CHAN_W;

  logic f_valid;
  cmd_t f_cmd;
  cmd_t dec_cmd;
  logic accept;

  assign in_stall = f_valid && q_status.full;
  assign push     = f_valid && !q_status.full;
  assign push_cmd = f_cmd;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    dec_cmd.channel = channel;
    dec_cmd.sample  = sample;
    dec_cmd.chan_ok = (CW+1)'(channel) < (CW+1)'(CHANNELS);
    unique case (mode)
      MODE_START:    dec_cmd.op = OP_START;
      MODE_CAL:      dec_cmd.op = OP_CAL;
      MODE_CLASSIFY: dec_cmd.op = OP_CLASSIFY;
      MODE_UNUSED:   dec_cmd.op = OP_IGNORE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= dec_cmd;
    end
  end

endmodule

// ===== hw/rtl/lscc_queue.sv =====
module lscc_queue import lscc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t q_status
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head           = slots[rd_ptr];
  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/lscc_back.sv =====
module lscc_back import lscc_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  cmd_t                head,
  input  queue_status_t       q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                classified,
  output logic                dark,
  output logic                all_separated,
  output logic                calibrated,
  output logic [SAMPLE_W-1:0] low_mark,
  output logic [SAMPLE_W-1:0] high_mark
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW    = (IDX_W > CHAN_W) ? IDX_W : CHAN_W;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int EXT_W = SAMPLE_W + 1;

  entry_t mem [CHANNELS];
  entry_t rd_data;
  entry_t fwd_data;
  logic   fwd_sel;

  logic                e1_valid;
  cmd_t                e1_cmd;
  logic                e1_fire;
  logic [IDX_W-1:0]    e1_idx;
  logic [IDX_W-1:0]    head_idx;
  logic [CW-1:0]       e1_wide;
  logic [CW-1:0]       head_wide;

  logic [CHANNELS-1:0] entry_valid;
  logic [CHANNELS-1:0] sep_bits;
  logic [CNT_W-1:0]    sep_count;
  logic [CNT_W-1:0]    sep_count_next;
  logic                calibrated_flag;

  entry_t              word;
  logic                ent_ok;
  logic [SAMPLE_W-1:0] cur_low;
  logic [SAMPLE_W-1:0] cur_high;
  logic                cur_held;
  logic [EXT_W-1:0]    m_ext;
  logic [EXT_W-1:0]    v_ext;
  logic [SAMPLE_W-1:0] new_low;
  logic [SAMPLE_W-1:0] new_high;
  logic [EXT_W-1:0]    black_top;
  logic [EXT_W-1:0]    white_bottom;
  logic                sep_new;
  logic [EXT_W-1:0]    blk_lo;
  logic [EXT_W-1:0]    blk_hi;
  logic [EXT_W-1:0]    wht_lo;
  logic [EXT_W-1:0]    wht_hi;
  logic                in_black;
  logic                in_white;
  logic                first_hit;
  logic                second_hit;
  logic                held_new;
  logic                wr_en;
  entry_t              wr_word;

  logic                res_classified;
  logic                res_dark;
  logic [SAMPLE_W-1:0] res_low;
  logic [SAMPLE_W-1:0] res_high;
  logic                res_calibrated;

  assign e1_fire   = e1_valid && (!out_valid || !out_stall);
  assign pop       = !q_status.empty && (!e1_valid || e1_fire);
  assign head_wide = CW'(head.channel);
  assign head_idx  = head_wide[IDX_W-1:0];
  assign e1_wide   = CW'(e1_cmd.channel);
  assign e1_idx    = e1_wide[IDX_W-1:0];

  // Entries not touched since the last start or reset read as the marks
  // that start or reset leave behind.
  always_comb begin
    word     = fwd_sel ? fwd_data : rd_data;
    ent_ok   = e1_cmd.chan_ok && entry_valid[e1_idx];
    cur_low  = ent_ok ? word.low  : (calibrated_flag ? MARK_TOP : MARK_BOTTOM);
    cur_high = ent_ok ? word.high : (calibrated_flag ? MARK_BOTTOM : MARK_TOP);
    cur_held = ent_ok ? word.held : 1'b0;
  end

  always_comb begin
    m_ext = EXT_W'(cfg.margin);
    v_ext = EXT_W'(e1_cmd.sample);

    new_low  = (e1_cmd.sample < cur_low)  ? e1_cmd.sample : cur_low;
    new_high = (e1_cmd.sample > cur_high) ? e1_cmd.sample : cur_high;
    black_top    = EXT_W'(new_low) + m_ext;
    white_bottom = (EXT_W'(new_high) >= m_ext) ? EXT_W'(new_high) - m_ext : '0;
    sep_new      = black_top < white_bottom;

    blk_lo = (EXT_W'(cur_low) >= m_ext) ? EXT_W'(cur_low) - m_ext : '0;
    blk_hi = EXT_W'(cur_low) + m_ext;
    wht_lo = (EXT_W'(cur_high) >= m_ext) ? EXT_W'(cur_high) - m_ext : '0;
    wht_hi = EXT_W'(cur_high) + m_ext;
    in_black   = (v_ext >= blk_lo) && (v_ext <= blk_hi);
    in_white   = (v_ext >= wht_lo) && (v_ext <= wht_hi);
    first_hit  = cfg.polarity ? in_white : in_black;
    second_hit = cfg.polarity ? in_black : in_white;
    held_new   = first_hit ? 1'b1 : (second_hit ? 1'b0 : cur_held);
  end

  always_comb begin
    wr_en          = 1'b0;
    wr_word.low    = cur_low;
    wr_word.high   = cur_high;
    wr_word.held   = cur_held;
    sep_count_next = sep_count;
    res_classified = 1'b0;
    res_dark       = cur_held;
    res_low        = cur_low;
    res_high       = cur_high;
    res_calibrated = calibrated_flag;
    unique case (e1_cmd.op)
      OP_START: begin
        sep_count_next = '0;
        res_dark       = 1'b0;
        res_low        = MARK_TOP;
        res_high       = MARK_BOTTOM;
        res_calibrated = 1'b1;
      end
      OP_CAL: begin
        if (e1_cmd.chan_ok) begin
          wr_en          = e1_fire;
          wr_word.low    = new_low;
          wr_word.high   = new_high;
          sep_count_next = sep_count + CNT_W'(sep_new) - CNT_W'(sep_bits[e1_idx]);
          res_low        = new_low;
          res_high       = new_high;
        end
      end
      OP_CLASSIFY: begin
        if (e1_cmd.chan_ok && calibrated_flag) begin
          wr_en          = e1_fire;
          wr_word.held   = held_new;
          res_classified = 1'b1;
          res_dark       = held_new;
        end
      end
      OP_IGNORE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[e1_idx] <= wr_word;
    end
    if (pop && head.chan_ok) begin
      rd_data <= mem[head_idx];
    end
  end

  // The beat leaving execute writes at the same edge the next one reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_sel <= 1'b0;
    end else if (pop) begin
      fwd_sel <= wr_en && head.chan_ok && (head_idx == e1_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fwd_data <= wr_word;
      e1_cmd   <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid        <= 1'b0;
      entry_valid     <= '0;
      sep_bits        <= '0;
      sep_count       <= '0;
      calibrated_flag <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        e1_valid <= 1'b1;
      end else if (e1_fire) begin
        e1_valid <= 1'b0;
      end
      if (e1_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (e1_fire) begin
        sep_count <= sep_count_next;
        if (e1_cmd.op == OP_START) begin
          entry_valid     <= '0;
          sep_bits        <= '0;
          calibrated_flag <= 1'b1;
        end else if (wr_en) begin
          entry_valid[e1_idx] <= 1'b1;
          if (e1_cmd.op == OP_CAL) begin
            sep_bits[e1_idx] <= sep_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e1_fire) begin
      classified    <= res_classified;
      dark          <= e1_cmd.chan_ok ? res_dark : 1'b0;
      low_mark      <= e1_cmd.chan_ok ? res_low  : '0;
      high_mark     <= e1_cmd.chan_ok ? res_high : '0;
      calibrated    <= res_calibrated;
      all_separated <= (sep_count_next == CNT_W'(CHANNELS));
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lscc_pkg::*;

  typedef struct packed {
    logic [MODE_W-1:0]   md;
    logic [CHAN_W-1:0]   ch;
    logic [SAMPLE_W-1:0] v;
  } sensor_beat_t;

  typedef struct packed {
    logic                classified;
    logic                dark;
    logic                all_sep;
    logic                calibrated;
    logic [SAMPLE_W-1:0] low;
    logic [SAMPLE_W-1:0] high;
  } reading_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   mode = MODE_START;
  logic [CHAN_W-1:0]   channel = '0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                classified;
  logic                dark;
  logic                all_separated;
  logic                calibrated;
  logic [SAMPLE_W-1:0] low_mark;
  logic [SAMPLE_W-1:0] high_mark;
  logic                cfg_write = 1'b0;
  logic                cfg_index = REG_MARGIN;
  logic [MARGIN_W-1:0] cfg_data = '0;

  line_sensor_calibrate_classify_core #(.CHANNELS(16)) dut (.*);

  always #2 clk = ~clk;

  // Predicted state of the sensor conditioner.
  int   low_rec [16];
  int   high_rec [16];
  bit   dark_hold [16];
  bit   split_ok [16];
  bit   cal_started = 1'b0;
  int   cur_margin = MARGIN_RESET;
  bit   cur_polarity = 1'b0;

  sensor_beat_t queued_samples[$];
  reading_t     pending_readings[$];

  // Stimulus shaping.
  int lvl_dark [16];
  int lvl_light [16];
  int gen_margin = MARGIN_RESET;
  int total_queued = 0;
  int idle_odds = 0;
  bit quiet = 1'b0;
  int send_gap = 0;
  int hold_left = 0;

  // Bookkeeping.
  int fault_count = 0;
  int mode_seen [4];
  int results_seen = 0;
  int dark_seen = 0;
  int all_split_seen = 0;

  initial begin
    for (int i = 0; i < 16; i++) begin
      low_rec[i] = 0;
      high_rec[i] = 1023;
      dark_hold[i] = 1'b0;
      split_ok[i] = 1'b0;
      lvl_dark[i] = 100;
      lvl_light[i] = 900;
    end
    for (int i = 0; i < 4; i++) mode_seen[i] = 0;
  end

  function automatic bit marks_split(int lo, int hi);
    int black_top;
    int white_bottom;
    black_top = lo + cur_margin;
    white_bottom = (hi >= cur_margin) ? hi - cur_margin : 0;
    return black_top < white_bottom;
  endfunction

  function automatic bit near_mark(int v, int centre);
    int lo;
    lo = (centre >= cur_margin) ? centre - cur_margin : 0;
    return v >= lo && v <= centre + cur_margin;
  endfunction

  function automatic reading_t predict_reading(sensor_beat_t b);
    reading_t r;
    int       ch;
    int       v;
    bit       blk;
    bit       wht;
    bit       all;
    ch = int'(b.ch);
    v = int'(b.v);
    r = '0;
    case (b.md)
      MODE_START: begin
        for (int i = 0; i < 16; i++) begin
          low_rec[i] = 1023;
          high_rec[i] = 0;
          dark_hold[i] = 1'b0;
          split_ok[i] = marks_split(1023, 0);
        end
        cal_started = 1'b1;
      end
      MODE_CAL: begin
        if (v < low_rec[ch]) low_rec[ch] = v;
        if (v > high_rec[ch]) high_rec[ch] = v;
        split_ok[ch] = marks_split(low_rec[ch], high_rec[ch]);
      end
      MODE_CLASSIFY: begin
        if (cal_started) begin
          blk = near_mark(v, low_rec[ch]);
          wht = near_mark(v, high_rec[ch]);
          // The zone tested first wins when the two zones overlap.
          if (cur_polarity ? wht : blk) dark_hold[ch] = 1'b1;
          else if (cur_polarity ? blk : wht) dark_hold[ch] = 1'b0;
          r.classified = 1'b1;
        end
      end
      default: ;
    endcase
    all = 1'b1;
    for (int i = 0; i < 16; i++) all &= split_ok[i];
    r.dark = dark_hold[ch];
    r.all_sep = all;
    r.calibrated = cal_started;
    r.low = SAMPLE_W'(low_rec[ch]);
    r.high = SAMPLE_W'(high_rec[ch]);
    return r;
  endfunction

  // Sender: one beat per handshake, random gaps unless the run is quiet.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_readings.push_back(predict_reading('{mode, channel, sample}));
        mode_seen[mode]++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (queued_samples.size() != 0) begin
          if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            mode <= queued_samples[0].md;
            channel <= queued_samples[0].ch;
            sample <= queued_samples[0].v;
            void'(queued_samples.pop_front());
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{classified, dark, all_separated, calibrated, low_mark, high_mark};
        results_seen++;
        if (got.dark) dark_seen++;
        if (got.all_sep) all_split_seen++;
        if (pending_readings.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result beat %0d arrived with nothing predicted", results_seen);
        end else begin
          want = pending_readings.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"result beat %0d: expected cls=%0b dark=%0b all=%0b cal=%0b ",
                        "low=%0d high=%0d, got cls=%0b dark=%0b all=%0b cal=%0b ",
                        "low=%0d high=%0d"}, results_seen,
                       want.classified, want.dark, want.all_sep, want.calibrated,
                       want.low, want.high, got.classified, got.dark, got.all_sep,
                       got.calibrated, got.low, got.high);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        hold_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int clip(int x);
    return (x < 0) ? 0 : (x > 1023) ? 1023 : x;
  endfunction

  task automatic push_beat(logic [MODE_W-1:0] md, int ch, int v);
    queued_samples.push_back('{md, CHAN_W'(ch), SAMPLE_W'(v)});
    total_queued++;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (queued_samples.size() != 0 || in_valid || pending_readings.size() != 0);
  endtask

  task automatic write_reg(logic idx, int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= MARGIN_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_MARGIN) begin
      cur_margin = val;
      gen_margin = val;
    end else begin
      cur_polarity = val[0];
    end
    @(negedge clk);
  endtask

  function automatic int pick_margin();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1023;
      2: return int'($urandom_range(0, 1023));
      default: return int'($urandom_range(0, 120));
    endcase
  endfunction

  // Start, then give every channel a dark and a light reading and maybe one between.
  task automatic calibrate_all();
    int off;
    int ch;
    int floor_light;
    off = $urandom_range(0, 15);
    push_beat(MODE_START, $urandom_range(0, 15), $urandom_range(0, 1023));
    for (int k = 0; k < 16; k++) begin
      ch = (k + off) % 16;
      lvl_dark[ch] = $urandom_range(0, 300);
      floor_light = lvl_dark[ch] + 2 * gen_margin + 1;
      if (floor_light > 1023 || $urandom_range(0, 9) == 0)
        lvl_light[ch] = $urandom_range(lvl_dark[ch], 1023);
      else
        lvl_light[ch] = $urandom_range(floor_light, 1023);
      push_beat(MODE_CAL, ch, lvl_light[ch]);
      push_beat(MODE_CAL, ch, lvl_dark[ch]);
      if ($urandom_range(0, 2) == 0)
        push_beat(MODE_CAL, ch, $urandom_range(lvl_dark[ch], lvl_light[ch]));
    end
  endtask

  // Mostly classify beats aimed at the zone edges, with a little noise mixed in.
  task automatic push_classify();
    int ch;
    int kind;
    int spread;
    int v;
    ch = $urandom_range(0, 15);
    kind = $urandom_range(0, 19);
    spread = int'($urandom_range(0, 2 * gen_margin + 4)) - gen_margin - 2;
    if (kind < 7) v = clip(lvl_dark[ch] + spread);
    else if (kind < 14) v = clip(lvl_light[ch] + spread);
    else if (kind < 16) v = $urandom_range(lvl_dark[ch], lvl_light[ch]);
    else v = $urandom_range(0, 1023);
    if (kind == 17) push_beat(MODE_CAL, ch, $urandom_range(0, 1023));
    else if (kind == 18) push_beat(MODE_UNUSED, ch, v);
    else push_beat(MODE_CLASSIFY, ch, v);
  endtask

  task automatic push_noise(int n);
    logic [MODE_W-1:0] md;
    for (int i = 0; i < n; i++) begin
      md = MODE_W'($urandom_range(1, 3));
      if ($urandom_range(0, 19) == 0) md = MODE_START;
      push_beat(md, $urandom_range(0, 15), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Before any start: tracking against the reset marks, ignored classify.
    push_beat(MODE_CAL, 0, 0);
    push_beat(MODE_CAL, 15, 1023);
    push_beat(MODE_CLASSIFY, 3, 512);
    push_beat(MODE_UNUSED, 7, 1023);
    push_beat(MODE_START, 9, 0);
    push_beat(MODE_CAL, 0, 0);
    push_beat(MODE_CAL, 0, 1023);
    push_beat(MODE_CLASSIFY, 0, 0);
    push_beat(MODE_CLASSIFY, 0, 1023);
    push_beat(MODE_CLASSIFY, 0, 500);
    push_beat(MODE_CLASSIFY, 0, 50);
    push_beat(MODE_CLASSIFY, 0, 51);
    push_beat(MODE_CLASSIFY, 0, 973);
    push_beat(MODE_UNUSED, 0, 0);
    // A channel left at its start marks has its zones swapped.
    push_beat(MODE_CLASSIFY, 1, 1000);
    push_beat(MODE_CLASSIFY, 1, 20);
    drain();

    write_reg(REG_MARGIN, 0);
    write_reg(REG_POLARITY, 1);
    push_beat(MODE_CAL, 2, 300);
    push_beat(MODE_CLASSIFY, 2, 300);
    push_beat(MODE_CLASSIFY, 2, 301);
    drain();

    // Widest margin: lower zone bounds saturate at zero.
    write_reg(REG_MARGIN, 1023);
    write_reg(REG_POLARITY, 0);
    push_beat(MODE_CLASSIFY, 2, 0);
    push_beat(MODE_CLASSIFY, 2, 1023);
    push_beat(MODE_CAL, 5, 1023);
    drain();

    while (total_queued < 910) begin
      if ($urandom_range(0, 3) != 0) write_reg(REG_MARGIN, pick_margin());
      if ($urandom_range(0, 2) == 0) write_reg(REG_POLARITY, $urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 4;
        default: idle_odds = 10;
      endcase
      if ($urandom_range(0, 4) != 0) begin
        // Skipping the start keeps old separation bits under a new margin.
        if ($urandom_range(0, 3) != 0) calibrate_all();
        repeat ($urandom_range(20, 70)) push_classify();
      end else begin
        push_noise(25);
      end
      drain();
    end

    quiet = 1'b1;
    write_reg(REG_MARGIN, $urandom_range(0, 60));
    write_reg(REG_POLARITY, $urandom_range(0, 1));
    calibrate_all();
    repeat (60) push_classify();
    drain();
    repeat (8) @(posedge clk);

    $display("beats: %0d start, %0d calibrate, %0d classify, %0d unused mode",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    $display("results: %0d checked, %0d dark, %0d with every channel separated",
             results_seen, dark_seen, all_split_seen);
    if (fault_count == 0) begin
      $display("line_sensor_calibrate_classify_core: match");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("line_sensor_calibrate_classify_core: mismatch");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d predictions outstanding", pending_readings.size());
    $display("line_sensor_calibrate_classify_core: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lscc_pkg.sv
hw/rtl/lscc_front.sv
hw/rtl/lscc_queue.sv
hw/rtl/lscc_back.sv
hw/rtl/line_sensor_calibrate_classify_core.sv
tb/tb.sv
